@@ rtl/ppb_pkg.sv @@
// Types, widths and constants for the periodic pair bond test.
// No dependencies; used by periodic_pair_bond_test.
package ppb_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned ELEM_W     = 2;
  localparam int unsigned POS_W      = 32;
  localparam int unsigned BOX_W      = 31;
  localparam int unsigned RECIP_W    = 40;
  localparam int unsigned CFG_W      = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned DIFF_W     = POS_W + 1;
  localparam int unsigned RECIP_SPLIT = 20;
  localparam int unsigned PPROD_W    = DIFF_W + RECIP_SPLIT;
  localparam int unsigned WSUM_W     = DIFF_W + RECIP_W + 1;
  localparam int unsigned CNT_SHIFT  = FRAC_BITS + 32;
  localparam int unsigned CRAW_W     = WSUM_W - CNT_SHIFT;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CMAG_W     = CNT_W + 1;
  localparam int unsigned BPROD_W    = CNT_W + BOX_W + 1;
  localparam int unsigned RES_W      = BPROD_W - 1;
  localparam int unsigned SQ_SPLIT   = 24;
  localparam int unsigned RHI_W      = RES_W - SQ_SPLIT;
  localparam int unsigned HH_W       = 2 * RHI_W;
  localparam int unsigned HL_W       = RHI_W + SQ_SPLIT;
  localparam int unsigned LL_W       = 2 * SQ_SPLIT;
  localparam int unsigned SQ_W       = 2 * RES_W;
  localparam int unsigned TOT_W      = SQ_W + 2;
  localparam int unsigned DIST_SHIFT = 2 * FRAC_BITS - 16;
  localparam int unsigned DIST_W     = 48;
  localparam int unsigned CUT_W      = 19;

  localparam logic [WSUM_W-1:0] ROUND_HALF = WSUM_W'(1) << (FRAC_BITS + 31);
  localparam logic [CMAG_W-1:0] LIM_POS    = CMAG_W'(32767);
  localparam logic [CMAG_W-1:0] LIM_NEG    = CMAG_W'(32768);

  localparam logic [BOX_W-1:0]   BOX_RESET   = BOX_W'(655360);
  localparam logic [RECIP_W-1:0] RECIP_RESET = RECIP_W'(429496730);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_A   = 3'd0,
    CFG_BOX_B   = 3'd1,
    CFG_BOX_C   = 3'd2,
    CFG_RECIP_A = 3'd3,
    CFG_RECIP_B = 3'd4,
    CFG_RECIP_C = 3'd5
  } cfg_reg_e;

  // squared cutoffs, 2^-16 square angstroms, order H C N O
  localparam logic [CUT_W-1:0] CUTOFF_SQ [4][4] = '{
    '{19'd36864,  19'd189399, 19'd147456, 19'd147456},
    '{19'd189399, 19'd189399, 19'd317194, 19'd212337},
    '{19'd147456, 19'd317194, 19'd167772, 19'd212337},
    '{19'd147456, 19'd212337, 19'd212337, 19'd128451}
  };

  typedef struct packed {
    logic [IDX_W-1:0]        first_index;
    logic [IDX_W-1:0]        second_index;
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic [ELEM_W-1:0]       first_element;
    logic [ELEM_W-1:0]       second_element;
  } pair_t;

  typedef struct packed {
    logic                    bonded;
    logic [DIST_W-1:0]       distance_sq;
    logic signed [CNT_W-1:0] image_shift_a;
    logic signed [CNT_W-1:0] image_shift_b;
    logic signed [CNT_W-1:0] image_shift_c;
  } result_t;

endpackage

@@ rtl/ppb_stream_if.sv @@
// Valid/ready stream channel carrying one word of type word_t.
// Used with ppb_pkg::pair_t and ppb_pkg::result_t.
interface ppb_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/periodic_pair_bond_test.sv @@
// Periodic pair bond test: minimum image squared distance and cutoff check.
// Depends on ppb_pkg and ppb_stream_if.
// Nine register stages; the result word is held in the last of them, out_q.
// Throughput one pair per cycle; the stages stall together when the output is held.
// Reset clears the stage valid bits and loads the box and reciprocal registers for a 10 angstrom cube.
module periodic_pair_bond_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppb_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ppb_pkg::CFG_W-1:0]     cfg_wdata_i,
  ppb_stream_if.sink                    pair_i,
  ppb_stream_if.source                  result_o
);

  localparam int unsigned NA = ppb_pkg::NUM_AXES;

  logic [ppb_pkg::BOX_W-1:0]   box_q   [NA];
  logic [ppb_pkg::RECIP_W-1:0] recip_q [NA];

  logic [9:1] v_q;
  logic       en;

  logic                       same_q [1:8];
  logic [ppb_pkg::CUT_W-1:0]  cut_q  [1:8];
  logic [ppb_pkg::POS_W-1:0]  pos_a  [NA];
  logic [ppb_pkg::POS_W-1:0]  pos_b  [NA];
  logic [ppb_pkg::CNT_W-1:0]  cnt_q  [NA][3:8];
  logic [ppb_pkg::SQ_W-1:0]   sq_q   [NA];
  logic [ppb_pkg::TOT_W-1:0]  tot_q;
  ppb_pkg::result_t           out_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NA; i++) begin
        box_q[i]   <= ppb_pkg::BOX_RESET;
        recip_q[i] <= ppb_pkg::RECIP_RESET;
      end
    end else if (cfg_we_i) begin
      unique case (ppb_pkg::cfg_reg_e'(cfg_idx_i))
        ppb_pkg::CFG_BOX_A:   box_q[0]   <= cfg_wdata_i[ppb_pkg::BOX_W-1:0];
        ppb_pkg::CFG_BOX_B:   box_q[1]   <= cfg_wdata_i[ppb_pkg::BOX_W-1:0];
        ppb_pkg::CFG_BOX_C:   box_q[2]   <= cfg_wdata_i[ppb_pkg::BOX_W-1:0];
        ppb_pkg::CFG_RECIP_A: recip_q[0] <= cfg_wdata_i[ppb_pkg::RECIP_W-1:0];
        ppb_pkg::CFG_RECIP_B: recip_q[1] <= cfg_wdata_i[ppb_pkg::RECIP_W-1:0];
        ppb_pkg::CFG_RECIP_C: recip_q[2] <= cfg_wdata_i[ppb_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // global stall
  assign en           = !v_q[9] || result_o.ready;
  assign pair_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[8:1], pair_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      same_q[1] <= (pair_i.data.first_index == pair_i.data.second_index);
      cut_q[1]  <= ppb_pkg::CUTOFF_SQ[pair_i.data.first_element][pair_i.data.second_element];
      for (int k = 2; k <= 8; k++) begin
        same_q[k] <= same_q[k-1];
        cut_q[k]  <= cut_q[k-1];
      end
    end
  end

  assign pos_a[0] = pair_i.data.first_x;
  assign pos_a[1] = pair_i.data.first_y;
  assign pos_a[2] = pair_i.data.first_z;
  assign pos_b[0] = pair_i.data.second_x;
  assign pos_b[1] = pair_i.data.second_y;
  assign pos_b[2] = pair_i.data.second_z;

  for (genvar ax = 0; ax < NA; ax++) begin : g_axis
    logic [ppb_pkg::DIFF_W-1:0]  diff;
    logic [ppb_pkg::DIFF_W-1:0]  d1_q, d2_q, d3_q, d4_q;
    logic                        neg1_q, neg2_q;
    logic [ppb_pkg::DIFF_W-1:0]  mag1_q;
    logic [ppb_pkg::PPROD_W-1:0] plo2_q, phi2_q;
    logic [ppb_pkg::WSUM_W-1:0]  wsum;
    logic [ppb_pkg::CRAW_W-1:0]  craw;
    logic [ppb_pkg::CMAG_W-1:0]  lim, cmag, cnt17;
    logic signed [ppb_pkg::BPROD_W-1:0] prod4_q;
    logic [ppb_pkg::BPROD_W-1:0] dext, rpos, rneg;
    logic [ppb_pkg::RES_W-1:0]   res5_q;
    logic [ppb_pkg::RHI_W-1:0]   rhi;
    logic [ppb_pkg::SQ_SPLIT-1:0] rlo;
    logic [ppb_pkg::HH_W-1:0]    hh6_q;
    logic [ppb_pkg::HL_W-1:0]    hl6_q;
    logic [ppb_pkg::LL_W-1:0]    ll6_q;

    assign diff = {pos_a[ax][ppb_pkg::POS_W-1], pos_a[ax]}
                - {pos_b[ax][ppb_pkg::POS_W-1], pos_b[ax]};

    // nearest image count, round half away from zero, clamp
    assign wsum = ppb_pkg::WSUM_W'(plo2_q)
                + (ppb_pkg::WSUM_W'(phi2_q) << ppb_pkg::RECIP_SPLIT)
                + ppb_pkg::ROUND_HALF;
    assign craw  = wsum[ppb_pkg::WSUM_W-1:ppb_pkg::CNT_SHIFT];
    assign lim   = neg2_q ? ppb_pkg::LIM_NEG : ppb_pkg::LIM_POS;
    assign cmag  = (craw > ppb_pkg::CRAW_W'(lim)) ? lim : craw[ppb_pkg::CMAG_W-1:0];
    assign cnt17 = neg2_q ? (~cmag + ppb_pkg::CMAG_W'(1)) : cmag;

    // residual and its magnitude
    assign dext = {{(ppb_pkg::BPROD_W-ppb_pkg::DIFF_W){d4_q[ppb_pkg::DIFF_W-1]}}, d4_q};
    assign rpos = dext - ppb_pkg::BPROD_W'(prod4_q);
    assign rneg = ppb_pkg::BPROD_W'(prod4_q) - dext;

    assign rhi = res5_q[ppb_pkg::RES_W-1:ppb_pkg::SQ_SPLIT];
    assign rlo = res5_q[ppb_pkg::SQ_SPLIT-1:0];

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_q   <= diff;
        neg1_q <= diff[ppb_pkg::DIFF_W-1];
        mag1_q <= diff[ppb_pkg::DIFF_W-1] ? (~diff + ppb_pkg::DIFF_W'(1)) : diff;

        d2_q   <= d1_q;
        neg2_q <= neg1_q;
        plo2_q <= ppb_pkg::PPROD_W'(mag1_q)
                * ppb_pkg::PPROD_W'(recip_q[ax][ppb_pkg::RECIP_SPLIT-1:0]);
        phi2_q <= ppb_pkg::PPROD_W'(mag1_q)
                * ppb_pkg::PPROD_W'(recip_q[ax][ppb_pkg::RECIP_W-1:ppb_pkg::RECIP_SPLIT]);

        d3_q         <= d2_q;
        cnt_q[ax][3] <= cnt17[ppb_pkg::CNT_W-1:0];

        d4_q    <= d3_q;
        prod4_q <= $signed(cnt_q[ax][3]) * $signed({1'b0, box_q[ax]});

        res5_q <= rpos[ppb_pkg::BPROD_W-1] ? rneg[ppb_pkg::RES_W-1:0]
                                           : rpos[ppb_pkg::RES_W-1:0];

        hh6_q <= ppb_pkg::HH_W'(rhi) * ppb_pkg::HH_W'(rhi);
        hl6_q <= ppb_pkg::HL_W'(rhi) * ppb_pkg::HL_W'(rlo);
        ll6_q <= ppb_pkg::LL_W'(rlo) * ppb_pkg::LL_W'(rlo);

        sq_q[ax] <= ppb_pkg::SQ_W'(ll6_q)
                  + (ppb_pkg::SQ_W'(hl6_q) << (ppb_pkg::SQ_SPLIT + 1))
                  + (ppb_pkg::SQ_W'(hh6_q) << (2 * ppb_pkg::SQ_SPLIT));

        for (int k = 4; k <= 8; k++) begin
          cnt_q[ax][k] <= cnt_q[ax][k-1];
        end
      end
    end
  end

  // sum of squares, scale, saturate, cutoff
  logic [ppb_pkg::TOT_W-ppb_pkg::DIST_SHIFT-1:0] scaled;
  logic                                          sat;

  assign scaled = tot_q[ppb_pkg::TOT_W-1:ppb_pkg::DIST_SHIFT];
  assign sat    = |scaled[ppb_pkg::TOT_W-ppb_pkg::DIST_SHIFT-1:ppb_pkg::DIST_W];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tot_q <= ppb_pkg::TOT_W'(sq_q[0]) + ppb_pkg::TOT_W'(sq_q[1])
             + ppb_pkg::TOT_W'(sq_q[2]);

      out_q.distance_sq   <= sat ? '1 : scaled[ppb_pkg::DIST_W-1:0];
      out_q.bonded        <= !same_q[8] && !sat
                           && (scaled[ppb_pkg::DIST_W-1:0] < ppb_pkg::DIST_W'(cut_q[8]));
      out_q.image_shift_a <= cnt_q[0][8];
      out_q.image_shift_b <= cnt_q[1][8];
      out_q.image_shift_c <= cnt_q[2][8];
    end
  end

  assign result_o.valid = v_q[9];
  assign result_o.data  = out_q;

  // checks
  a_take_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_i.valid && pair_i.ready |=> v_q[1])
    else $error("accepted pair did not enter the first stage");

  a_ready_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[9] |-> pair_i.ready)
    else $error("input stalled with an empty output stage");

  a_bond_below_cut : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.data.bonded
      |-> result_o.data.distance_sq < ppb_pkg::DIST_W'(ppb_pkg::CUTOFF_SQ[1][2]))
    else $error("bond flagged beyond the largest cutoff");

  a_same_not_bonded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v_q[8] && same_q[8] |=> !result_o.data.bonded)
    else $error("pair with the same index flagged as bonded");

endmodule
